FILE: hdl/mfng_pkg.sv
// ----------------------------------------------------------------------------
// mfng_pkg: shared types and constants of the multiband FIR noise gate
// Request opcodes, configuration indexes, sequencer states and MAC control.
// ----------------------------------------------------------------------------
package mfng_pkg;

  localparam int OP_W      = 3;
  localparam int SMP_W     = 16;
  localparam int BSEL_W    = 3;
  localparam int IDX_W     = 8;
  localparam int LV_W      = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int COEF_W    = 18;
  localparam int THR_W     = 17;
  localparam int FADE_W    = 17;
  localparam int ENV_W     = 20;
  localparam int MUL_A_W   = 18;

  localparam logic [ENV_W-1:0]  ENV_MAX   = '1;
  localparam logic [FADE_W-1:0] FADE_UNIT = 17'd65536;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE    = 3'd0,
    OP_LOAD_COEF = 3'd1,
    OP_LOAD_THR  = 3'd2,
    OP_LOAD_FADE = 3'd3,
    OP_RESTART   = 3'd4
  } op_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAPS   = 3'd0,
    CFG_BANDS  = 3'd1,
    CFG_ATTACK = 3'd2,
    CFG_DECAY  = 3'd3,
    CFG_GAIN   = 3'd4
  } cfg_index_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_WRITE, S_BSTART, S_MAC, S_DRAIN, S_VAL,
    S_ENV_A, S_ENV_B, S_ENV_C, S_ENV_D, S_CMP,
    S_FADE_A, S_FADE_B, S_FADE_C, S_NEXT, S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    MAC_HOLD, MAC_CLR, MAC_LOAD, MAC_ADD
  } mac_op_t;

  typedef struct packed {
    mac_op_t op;
  } mac_ctl_t;

endpackage

FILE: hdl/mfng_if.sv
// ----------------------------------------------------------------------------
// mfng_if: request and result channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface mfng_in_if;
  import mfng_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [SMP_W-1:0]  sample_in;
  logic [BSEL_W-1:0]        band_sel;
  logic [IDX_W-1:0]         entry_index;
  logic signed [LV_W-1:0]   load_value;
  modport source (output valid, operation, sample_in, band_sel, entry_index,
                  load_value, input ready);
  modport sink   (input valid, operation, sample_in, band_sel, entry_index,
                  load_value, output ready);
endinterface

interface mfng_out_if;
  import mfng_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [SMP_W-1:0]  out_sample;
  logic                     clipped;
  modport source (output valid, out_sample, clipped, input ready);
  modport sink   (input valid, out_sample, clipped, output ready);
endinterface

FILE: hdl/mfng_ram.sv
// ----------------------------------------------------------------------------
// mfng_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mfng_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/mfng_mac.sv
// ----------------------------------------------------------------------------
// mfng_mac: shared multiply-accumulate unit
// Registered signed product followed by a clear/load/add accumulator.
// ----------------------------------------------------------------------------
module mfng_mac #(
  parameter int A_W   = 18,
  parameter int B_W   = 27,
  parameter int ACC_W = 54
) (
  input  logic                    clk,
  input  mfng_pkg::mac_ctl_t      ctl,
  input  logic signed [A_W-1:0]   a,
  input  logic signed [B_W-1:0]   b,
  output logic signed [ACC_W-1:0] acc
);
  import mfng_pkg::*;

  logic signed [A_W+B_W-1:0] prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   prod_ext;

  assign prod_ext = ACC_W'(prod_r);
  assign acc      = acc_r;

  // register the product, then fold it into the accumulator
  always_ff @(posedge clk) begin
    prod_r <= a * b;
    case (ctl.op)
      MAC_CLR:  acc_r <= '0;
      MAC_LOAD: acc_r <= prod_ext;
      MAC_ADD:  acc_r <= acc_r + prod_ext;
      default:  acc_r <= acc_r;
    endcase
  end
endmodule

FILE: hdl/multiband_fir_noise_gate.sv
// ----------------------------------------------------------------------------
// multiband_fir_noise_gate: multiband FIR filter bank with noise gate
// Per-band FIR over a sample ring, envelope follower, faded gating and a
// saturated sum, all on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        carries
//  in_req    in   valid/ready      operation, sample, band, index, load value
//  out_res   out  valid/ready      out_sample, clipped (sample requests only)
//  cfg_*     in   cfg_we           register index and write data
//
//  A sample request runs each band through the single MAC, which issues one
//  tap per cycle; loads are taken without leaving the idle state. After reset
//  and after restart the ring is cleared with in_req.ready low. A result
//  waits in the output register while the next request is taken; only the
//  final step of a sample stalls on out_res.ready.
// ----------------------------------------------------------------------------
module multiband_fir_noise_gate #(
  parameter int MAX_TAPS   = 256,
  parameter int NUM_BANDS  = 8,
  parameter int FADE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mfng_in_if.sink                           in_req,
  mfng_out_if.source                        out_res,
  input  logic                              cfg_we,
  input  logic [mfng_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mfng_pkg::CFG_W-1:0]        cfg_wdata
);
  import mfng_pkg::*;

  localparam int RA_W  = $clog2(MAX_TAPS);
  localparam int TC_W  = $clog2(MAX_TAPS + 1);
  localparam int BA_W  = $clog2(NUM_BANDS);
  localparam int BC_W  = $clog2(NUM_BANDS + 1);
  localparam int FP_W  = $clog2(FADE_DEPTH);
  localparam int CDEP  = NUM_BANDS * MAX_TAPS;
  localparam int CA_W  = $clog2(CDEP);
  localparam int VAL_W = 18 + TC_W;
  localparam int B_W   = VAL_W;
  localparam int MAC_W = MUL_A_W + B_W + TC_W;
  localparam int TOT_W = VAL_W + BC_W;

  // configuration registers
  logic [8:0]  taps_cfg_r, attack_cfg_r;
  logic [3:0]  bands_cfg_r;
  logic [15:0] decay_r, gain_r;

  // sequencer and datapath registers
  seq_state_t state_r, state_nxt;
  logic [RA_W-1:0]  clr_r, wp_r, start_r, ra_r;
  logic [TC_W-1:0]  k_r;
  logic [CA_W-1:0]  base_r;
  logic [BA_W-1:0]  b_r;
  logic             iss_r, mulv_r;
  logic signed [SMP_W-1:0] smp_r;
  logic signed [VAL_W-1:0] val_r;
  logic [ENV_W-1:0] mag_r, envn_r;
  logic signed [TOT_W-1:0] total_r;
  logic [ENV_W-1:0]  env_r    [NUM_BANDS];
  logic              fading_r [NUM_BANDS];
  logic [FP_W-1:0]   fpos_r   [NUM_BANDS];
  logic [THR_W-1:0]  thr_r    [NUM_BANDS];
  logic              out_v_r, clip_r;
  logic signed [SMP_W-1:0] out_smp_r;

  // effective configuration
  logic [TC_W-1:0] taps_eff;
  logic [BC_W-1:0] bands_eff;
  logic [FP_W-1:0] att_m1;
  logic [TC_W:0]   start_w;

  always_comb begin
    if (32'(taps_cfg_r) > MAX_TAPS) taps_eff = TC_W'(MAX_TAPS);
    else                             taps_eff = TC_W'(taps_cfg_r);
    if (32'(bands_cfg_r) > NUM_BANDS) bands_eff = BC_W'(NUM_BANDS);
    else                              bands_eff = BC_W'(bands_cfg_r);
    if (attack_cfg_r == '0)                  att_m1 = '0;
    else if (32'(attack_cfg_r) > FADE_DEPTH) att_m1 = FP_W'(FADE_DEPTH - 1);
    else                                     att_m1 = FP_W'(attack_cfg_r - 9'd1);
    if ((TC_W+1)'(wp_r) >= (TC_W+1)'(taps_eff))
      start_w = (TC_W+1)'(wp_r) - (TC_W+1)'(taps_eff);
    else
      start_w = (TC_W+1)'(wp_r) + (TC_W+1)'(MAX_TAPS) - (TC_W+1)'(taps_eff);
  end

  // request decode
  logic in_acc, issue, out_take, last_band;
  assign in_req.ready = (state_r == S_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign issue        = (state_r == S_MAC) && (k_r < taps_eff);
  assign out_take     = !out_v_r || out_res.ready;
  assign last_band    = (BC_W'(b_r) + BC_W'(1)) >= bands_eff;

  logic coef_ok, band_ok, fade_ok;
  assign band_ok = 32'(in_req.band_sel) < NUM_BANDS;
  assign coef_ok = band_ok && (32'(in_req.entry_index) < MAX_TAPS);
  assign fade_ok = 32'(in_req.entry_index) < FADE_DEPTH;

  // memories
  logic               ring_we;
  logic [RA_W-1:0]    ring_wa;
  logic [SMP_W-1:0]   ring_wd, ring_rd;
  logic [COEF_W-1:0]  coef_rd;
  logic [FADE_W-1:0]  fade_rd, fade_wd;
  logic [FP_W-1:0]    fade_ra;
  logic [CA_W-1:0]    coef_wa;
  logic               coef_we, fade_we;
  logic signed [LV_W-1:0] lv;

  assign lv      = in_req.load_value;
  assign ring_we = (state_r == S_CLEAR) || (state_r == S_WRITE);
  assign ring_wa = (state_r == S_CLEAR) ? clr_r : wp_r;
  assign ring_wd = (state_r == S_CLEAR) ? '0 : smp_r;
  assign coef_we = in_acc && (op_code_t'(in_req.operation) == OP_LOAD_COEF) && coef_ok;
  assign coef_wa = CA_W'(32'(in_req.band_sel) * MAX_TAPS + 32'(in_req.entry_index));
  assign fade_we = in_acc && (op_code_t'(in_req.operation) == OP_LOAD_FADE) && fade_ok;
  assign fade_wd = lv[LV_W-1] ? '0 :
                   (lv > $signed(LV_W'(65536))) ? FADE_UNIT : lv[FADE_W-1:0];

  mfng_ram #(.WIDTH(SMP_W), .DEPTH(MAX_TAPS)) u_ring (
    .clk(clk), .we(ring_we), .waddr(ring_wa), .wdata(ring_wd),
    .raddr(ra_r), .rdata(ring_rd)
  );

  mfng_ram #(.WIDTH(COEF_W), .DEPTH(CDEP)) u_coef (
    .clk(clk), .we(coef_we), .waddr(coef_wa), .wdata(lv[COEF_W-1:0]),
    .raddr(base_r + CA_W'(k_r)), .rdata(coef_rd)
  );

  mfng_ram #(.WIDTH(FADE_W), .DEPTH(FADE_DEPTH)) u_fade (
    .clk(clk), .we(fade_we), .waddr(FP_W'(in_req.entry_index)), .wdata(fade_wd),
    .raddr(fade_ra), .rdata(fade_rd)
  );

  // shared MAC with operand selection
  mac_ctl_t mac_ctl;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [B_W-1:0]     mul_b;
  logic signed [MAC_W-1:0]   acc;

  mfng_mac #(.A_W(MUL_A_W), .B_W(B_W), .ACC_W(MAC_W)) u_mac (
    .clk(clk), .ctl(mac_ctl), .a(mul_a), .b(mul_b), .acc(acc)
  );

  // band fade position for the gated path
  logic [FP_W-1:0] fp;
  logic            gate;
  assign fp      = fading_r[b_r] ? fpos_r[b_r] : att_m1;
  assign gate    = envn_r < ENV_W'(thr_r[b_r]);
  assign fade_ra = fp;

  // magnitude and envelope results
  logic [VAL_W-1:0] absval;
  logic [ENV_W-1:0] mag_w;
  logic [ENV_W-1:0] env_dec;
  logic signed [VAL_W-1:0] val_w;
  logic signed [TOT_W-1:0] gated_w, val_ext;
  assign val_w   = acc[VAL_W+15:16];
  assign absval  = val_r[VAL_W-1] ? VAL_W'(-val_r) : VAL_W'(val_r);
  assign mag_w   = (absval > VAL_W'(ENV_MAX)) ? ENV_MAX : absval[ENV_W-1:0];
  assign env_dec = (|acc[MAC_W-1:36]) ? ENV_MAX : acc[35:16];
  assign gated_w = acc[TOT_W+15:16];
  assign val_ext = TOT_W'(val_r);

  logic clip_hi, clip_lo;
  assign clip_hi = !total_r[TOT_W-1] && (|total_r[TOT_W-2:15]);
  assign clip_lo = total_r[TOT_W-1] && !(&total_r[TOT_W-2:15]);

  // next state and MAC control
  always_comb begin
    state_nxt  = state_r;
    mac_ctl.op = MAC_HOLD;
    mul_a      = coef_rd;
    mul_b      = B_W'($signed(ring_rd));
    case (state_r)
      S_CLEAR: begin
        if (clr_r == RA_W'(MAX_TAPS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (op_code_t'(in_req.operation) == OP_SAMPLE)       state_nxt = S_WRITE;
          else if (op_code_t'(in_req.operation) == OP_RESTART) state_nxt = S_CLEAR;
        end
      end
      S_WRITE: begin
        state_nxt = (bands_eff == '0) ? S_DONE : S_BSTART;
      end
      S_BSTART: begin
        mac_ctl.op = MAC_CLR;
        state_nxt  = S_MAC;
      end
      S_MAC: begin
        if (mulv_r) mac_ctl.op = MAC_ADD;
        if (!issue) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (mulv_r) mac_ctl.op = MAC_ADD;
        if (!iss_r && !mulv_r) state_nxt = S_VAL;
      end
      S_VAL: state_nxt = S_ENV_A;
      S_ENV_A: begin
        mul_a = MUL_A_W'(decay_r);
        mul_b = B_W'(env_r[b_r]);
        state_nxt = (mag_w > env_r[b_r]) ? S_CMP : S_ENV_B;
      end
      S_ENV_B: begin
        mul_a      = MUL_A_W'(gain_r);
        mul_b      = B_W'(mag_r);
        mac_ctl.op = MAC_LOAD;
        state_nxt  = S_ENV_C;
      end
      S_ENV_C: begin
        mac_ctl.op = MAC_ADD;
        state_nxt  = S_ENV_D;
      end
      S_ENV_D: state_nxt = S_CMP;
      S_CMP: state_nxt = gate ? S_FADE_A : S_NEXT;
      S_FADE_A: begin
        mul_a     = MUL_A_W'(fade_rd);
        mul_b     = val_r;
        state_nxt = S_FADE_B;
      end
      S_FADE_B: begin
        mac_ctl.op = MAC_LOAD;
        state_nxt  = S_FADE_C;
      end
      S_FADE_C: state_nxt = S_NEXT;
      S_NEXT: state_nxt = last_band ? S_DONE : S_BSTART;
      S_DONE: begin
        if (out_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_cfg_r   <= 9'd256;
      bands_cfg_r  <= 4'd8;
      attack_cfg_r <= 9'd16;
      decay_r      <= 16'd65208;
      gain_r       <= 16'd328;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_TAPS:   taps_cfg_r   <= cfg_wdata[8:0];
        CFG_BANDS:  bands_cfg_r  <= cfg_wdata[3:0];
        CFG_ATTACK: attack_cfg_r <= cfg_wdata[8:0];
        CFG_DECAY:  decay_r      <= cfg_wdata;
        CFG_GAIN:   gain_r       <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // control counters and per-band state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      wp_r    <= '0;
      iss_r   <= 1'b0;
      mulv_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int i = 0; i < NUM_BANDS; i++) begin
        env_r[i]    <= '0;
        fading_r[i] <= 1'b0;
      end
    end else begin
      iss_r  <= issue;
      mulv_r <= iss_r;
      // raise on a finished sample, drop once the result is taken
      out_v_r <= ((state_r == S_DONE) && out_take) || (out_v_r && !out_res.ready);
      case (state_r)
        S_CLEAR: clr_r <= clr_r + RA_W'(1);
        S_IDLE: begin
          clr_r <= '0;
          if (in_acc && (op_code_t'(in_req.operation) == OP_RESTART)) begin
            wp_r <= '0;
            for (int i = 0; i < NUM_BANDS; i++) begin
              env_r[i]    <= '0;
              fading_r[i] <= 1'b0;
            end
          end
        end
        S_WRITE: begin
          wp_r <= (wp_r == RA_W'(MAX_TAPS - 1)) ? '0 : wp_r + RA_W'(1);
        end
        S_CMP: begin
          env_r[b_r] <= envn_r;
          if (gate) begin
            fading_r[b_r] <= 1'b1;
            fpos_r[b_r]   <= (fp == '0) ? '0 : fp - FP_W'(1);
          end else begin
            fading_r[b_r] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath payload registers
  always_ff @(posedge clk) begin
    if (in_acc && (op_code_t'(in_req.operation) == OP_LOAD_THR) && band_ok) begin
      thr_r[BA_W'(in_req.band_sel)] <= lv[LV_W-1] ? '0 : lv[THR_W-1:0];
    end
    case (state_r)
      S_IDLE: smp_r <= in_req.sample_in;
      S_WRITE: begin
        start_r <= RA_W'(start_w);
        b_r     <= '0;
        base_r  <= '0;
        total_r <= '0;
      end
      S_BSTART: begin
        k_r  <= '0;
        ra_r <= start_r;
      end
      S_MAC: begin
        if (issue) begin
          k_r  <= k_r + TC_W'(1);
          ra_r <= (ra_r == RA_W'(MAX_TAPS - 1)) ? '0 : ra_r + RA_W'(1);
        end
      end
      S_VAL: val_r <= val_w;
      S_ENV_A: begin
        if (mag_w > env_r[b_r]) envn_r <= mag_w;
      end
      S_ENV_D: envn_r <= env_dec;
      S_CMP: begin
        if (!gate) total_r <= total_r + val_ext;
      end
      S_FADE_C: total_r <= total_r + gated_w;
      S_NEXT: begin
        b_r    <= b_r + BA_W'(1);
        base_r <= base_r + CA_W'(MAX_TAPS);
      end
      S_DONE: begin
        if (out_take) begin
          clip_r    <= clip_hi || clip_lo;
          out_smp_r <= clip_hi ? 16'sh7FFF : clip_lo ? -16'sh8000 : total_r[15:0];
        end
      end
      default: ;
    endcase
    // hold the magnitude of the freshly registered band value
    if (state_r == S_ENV_A) begin
      mag_r <= mag_w;
    end
  end

  // result channel
  assign out_res.valid      = out_v_r;
  assign out_res.out_sample = out_smp_r;
  assign out_res.clipped    = clip_r;

endmodule

FILE: verif/multiband_fir_noise_gate_tb.sv
// ----------------------------------------------------------------------------
// multiband_fir_noise_gate_tb: self-checking bench of the multiband noise gate
// Loads the coefficients, thresholds and fade entries in use, then drives
// directed and random requests under several register settings while both
// channels stall in random bursts. A behavioral predictor of the filter bank,
// envelopes and gating computes each expected output sample, checked field
// by field.
// ----------------------------------------------------------------------------
module multiband_fir_noise_gate_tb;
  import mfng_pkg::*;

  localparam int RING_LEN   = 256;
  localparam int BAND_CNT   = 8;
  localparam int FADE_LEN   = 256;
  localparam int TAP_LOADS  = 16;
  localparam int FADE_LOADS = 32;
  localparam int CYCLE_CAP  = 3000000;
  localparam int SETTLE_CYC = 320;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic signed [SMP_W-1:0] smp;
    logic [BSEL_W-1:0]       band;
    logic [IDX_W-1:0]        idx;
    logic signed [LV_W-1:0]  lv;
  } gate_req_t;

  typedef struct {
    logic signed [SMP_W-1:0] smp;
    logic                    clip;
  } gate_res_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  mfng_in_if  in_req ();
  mfng_out_if out_res ();

  multiband_fir_noise_gate dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor registers and state
  int unsigned taps_reg, bands_reg, attack_reg, decay_reg, gain_reg;
  logic signed [SMP_W-1:0] ring [RING_LEN];
  int unsigned wr_pos;
  int coef [BAND_CNT*RING_LEN];
  int thresh [BAND_CNT];
  int fade_gain [FADE_LEN];
  longint envelope [BAND_CNT];
  bit fading [BAND_CNT];
  int unsigned fade_idx [BAND_CNT];

  gate_req_t pending_reqs[$];
  gate_res_t expected_samples[$];
  gate_req_t req_on_bus;
  int unsigned in_flight = 0;
  int unsigned in_gap = 0, out_gap = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned attack_eff();
    if (attack_reg == 0) return 1;
    if (attack_reg > FADE_LEN) return FADE_LEN;
    return attack_reg;
  endfunction

  function automatic void clear_gate_state();
    for (int i = 0; i < RING_LEN; i++) ring[i] = '0;
    wr_pos = 0;
    for (int b = 0; b < BAND_CNT; b++) begin
      envelope[b] = 0;
      fading[b] = 1'b0;
      fade_idx[b] = attack_eff() - 1;
    end
  endfunction

  // Compute the gated band sum for one sample
  function automatic void run_filter_bank(logic signed [SMP_W-1:0] smp);
    int unsigned taps, bands, att, start;
    longint acc, val, mag, env, total;
    gate_res_t res;
    taps  = (taps_reg > RING_LEN) ? RING_LEN : taps_reg;
    bands = (bands_reg > BAND_CNT) ? BAND_CNT : bands_reg;
    att   = attack_eff() - 1;
    start = (wr_pos + RING_LEN - taps) % RING_LEN;
    total = 0;
    ring[wr_pos] = smp;
    for (int b = 0; b < bands; b++) begin
      acc = 0;
      for (int k = 0; k < taps; k++)
        acc += longint'(coef[b*RING_LEN+k]) * longint'(ring[(start+k) % RING_LEN]);
      val = acc >>> 16;
      mag = (val < 0) ? -val : val;
      if (mag > 64'sd1048575) mag = 64'sd1048575;
      env = envelope[b];
      if (mag > env) env = mag;
      else begin
        env = (longint'(decay_reg) * env + longint'(gain_reg) * mag) >>> 16;
        if (env > 64'sd1048575) env = 64'sd1048575;
      end
      envelope[b] = env;
      if (env < longint'(thresh[b])) begin
        if (!fading[b]) begin
          fade_idx[b] = att;
          fading[b] = 1'b1;
        end
        fade_idx[b] = fade_idx[b] % FADE_LEN;
        total += (val * longint'(fade_gain[fade_idx[b]])) >>> 16;
        if (fade_idx[b] > 0) fade_idx[b] = fade_idx[b] - 1;
      end else begin
        total += val;
        fading[b] = 1'b0;
      end
    end
    res.clip = 1'b0;
    if (total > 32767) begin
      total = 32767;
      res.clip = 1'b1;
    end else if (total < -32768) begin
      total = -32768;
      res.clip = 1'b1;
    end
    res.smp = total[SMP_W-1:0];
    wr_pos = (wr_pos + 1) % RING_LEN;
    expected_samples.push_back(res);
  endfunction

  function automatic void model_request(gate_req_t r);
    case (r.op)
      OP_SAMPLE:    run_filter_bank(r.smp);
      OP_LOAD_COEF: coef[r.band*RING_LEN + r.idx] = int'(r.lv);
      OP_LOAD_THR:  thresh[r.band] = (r.lv < 0) ? 0 : int'(r.lv);
      OP_LOAD_FADE: fade_gain[r.idx] = (r.lv < 0) ? 0 : ((r.lv > 65536) ? 65536 : int'(r.lv));
      OP_RESTART:   clear_gate_state();
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  task automatic queue_req(logic [OP_W-1:0] op, logic signed [SMP_W-1:0] smp,
                           logic [BSEL_W-1:0] band, logic [IDX_W-1:0] idx,
                           logic signed [LV_W-1:0] lv);
    gate_req_t r;
    r.op = op; r.smp = smp; r.band = band; r.idx = idx; r.lv = lv;
    pending_reqs.push_back(r);
    in_flight++;
  endtask

  // Random request: mostly samples, then loads, restart and unused codes
  task automatic queue_random_req();
    int unsigned pick;
    logic signed [LV_W-1:0] lv;
    pick = $urandom_range(0, 99);
    lv = LV_W'($urandom);
    if (pick < 60) begin
      queue_req(OP_SAMPLE, SMP_W'($urandom), BSEL_W'($urandom), IDX_W'($urandom),
                LV_W'($urandom));
    end else if (pick < 75) begin
      if ($urandom_range(0, 3) != 0) lv = $signed(lv[13:0]);
      queue_req(OP_LOAD_COEF, SMP_W'($urandom), BSEL_W'($urandom), IDX_W'($urandom), lv);
    end else if (pick < 85) begin
      if ($urandom_range(0, 2) != 0) lv = LV_W'($urandom_range(0, 3000));
      queue_req(OP_LOAD_THR, SMP_W'($urandom), BSEL_W'($urandom), IDX_W'($urandom), lv);
    end else if (pick < 93) begin
      if ($urandom_range(0, 2) != 0) lv = LV_W'($urandom_range(0, 65536));
      queue_req(OP_LOAD_FADE, SMP_W'($urandom), BSEL_W'($urandom), IDX_W'($urandom), lv);
    end else if (pick < 97) begin
      queue_req(OP_RESTART, SMP_W'($urandom), BSEL_W'($urandom), IDX_W'($urandom),
                LV_W'($urandom));
    end else begin
      queue_req(OP_W'($urandom_range(5, 7)), SMP_W'($urandom), BSEL_W'($urandom),
                IDX_W'($urandom), LV_W'($urandom));
    end
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_TAPS:   taps_reg   = val & 16'h1FF;
      CFG_BANDS:  bands_reg  = val & 16'hF;
      CFG_ATTACK: attack_reg = val & 16'h1FF;
      CFG_DECAY:  decay_reg  = val;
      CFG_GAIN:   gain_reg   = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(int unsigned t, int unsigned b, int unsigned a,
                          int unsigned d, int unsigned g);
    write_reg(CFG_TAPS, CFG_W'(t));
    write_reg(CFG_BANDS, CFG_W'(b));
    write_reg(CFG_ATTACK, CFG_W'(a));
    write_reg(CFG_DECAY, CFG_W'(d));
    write_reg(CFG_GAIN, CFG_W'(g));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every request is taken and every result seen, then settle
  task automatic drain();
    wait (in_flight == 0 && expected_samples.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Request driver
  always @(posedge clk) begin
    bit nv;
    if (!rst_n) begin
      in_req.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        model_request(req_on_bus);
        in_flight--;
      end
      if (!in_req.valid || in_req.ready) begin
        nv = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_reqs.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 16);
        end else if (pending_reqs.size() > 0) begin
          req_on_bus = pending_reqs.pop_front();
          nv = 1'b1;
          in_req.operation   <= req_on_bus.op;
          in_req.sample_in   <= req_on_bus.smp;
          in_req.band_sel    <= req_on_bus.band;
          in_req.entry_index <= req_on_bus.idx;
          in_req.load_value  <= req_on_bus.lv;
        end
        in_req.valid <= nv;
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin
    gate_res_t want;
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      out_gap = 0;
    end else begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
        $display("TEST FAILED");
        $finish;
      end
      if (out_res.valid && out_res.ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected result", out_res.out_sample, 0);
        end else begin
          want = expected_samples.pop_front();
          if (out_res.out_sample !== want.smp)
            report_mismatch("out_sample", out_res.out_sample, want.smp);
          if (out_res.clipped !== want.clip)
            report_mismatch("clipped", out_res.clipped, want.clip);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_res.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_gap = $urandom_range(1, 16);
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned settings [7][5];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_req.valid = 1'b0;
    in_req.operation = '0;
    in_req.sample_in = '0;
    in_req.band_sel = '0;
    in_req.entry_index = '0;
    in_req.load_value = '0;
    out_res.ready = 1'b0;
    taps_reg = 256; bands_reg = 8; attack_reg = 16; decay_reg = 65208; gain_reg = 328;
    clear_gate_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Small filters first; fill the entries that the settings below can reach:
    // the first taps of every band and both ends of the fade table
    set_regs(2, 2, 1, 0, 0);
    for (int i = 0; i < FADE_LOADS; i++) begin
      queue_req(OP_LOAD_FADE, 0, 0, IDX_W'(i), LV_W'($urandom_range(0, 65536)));
      queue_req(OP_LOAD_FADE, 0, 0, IDX_W'(FADE_LEN - 1 - i),
                LV_W'($urandom_range(0, 65536)));
    end
    for (int b = 0; b < BAND_CNT; b++) begin
      queue_req(OP_LOAD_THR, 0, BSEL_W'(b), 0, LV_W'($urandom_range(0, 2000)));
      for (int k = 0; k < TAP_LOADS; k++)
        queue_req(OP_LOAD_COEF, 0, BSEL_W'(b), IDX_W'(k), $signed(14'($urandom)));
    end

    // Directed: extremes, clipping, every opcode and the clamped loads
    queue_req(OP_LOAD_COEF, 0, 0, 0, 18'sd131071);
    queue_req(OP_LOAD_COEF, 0, 0, 1, 18'sd131071);
    queue_req(OP_LOAD_COEF, 0, 1, 0, -18'sd131072);
    queue_req(OP_LOAD_COEF, 0, 1, 1, 18'sd131071);
    queue_req(OP_LOAD_THR, 0, 0, 0, -18'sd131072);
    queue_req(OP_LOAD_THR, 0, 1, 0, 18'sd131071);
    queue_req(OP_LOAD_FADE, 0, 0, 0, 18'sd131071);
    queue_req(OP_LOAD_FADE, 0, 0, 255, -18'sd5);
    queue_req(OP_SAMPLE, 16'sh7FFF, 0, 0, 0);
    queue_req(OP_SAMPLE, 16'sh7FFF, 0, 0, 0);
    queue_req(OP_SAMPLE, -16'sh8000, 0, 0, 0);
    queue_req(OP_SAMPLE, -16'sh8000, 0, 0, 0);
    queue_req(OP_SAMPLE, 0, 7, 255, 0);
    queue_req(3'd5, 16'sh7FFF, 7, 255, 18'sd131071);
    queue_req(3'd6, 0, 0, 0, 0);
    queue_req(3'd7, -1, 7, 255, -1);
    queue_req(OP_RESTART, 0, 0, 0, 0);
    queue_req(OP_SAMPLE, 16'sh1234, 0, 0, 0);
    queue_req(OP_LOAD_THR, 0, 0, 0, 18'sd131071);
    queue_req(OP_SAMPLE, -16'sh0100, 0, 0, 0);
    queue_req(OP_SAMPLE, 16'sh0100, 0, 0, 0);
    drain();

    // Register sweeps: taps, bands, attack, decay, gain
    settings = '{'{16, 8, 511, 65535, 65535}, '{0, 15, 0, 0, 65535},
                 '{16, 0, 32, 65535, 0}, '{4, 8, 16, 65208, 328},
                 '{9, 5, 3, 40000, 20000}, '{16, 3, 20, 60000, 5000},
                 '{2, 8, 8, 65000, 500}};
    for (int p = 0; p < 7; p++) begin
      set_regs(settings[p][0], settings[p][1], settings[p][2],
               settings[p][3], settings[p][4]);
      if (p == 6) quiet = 1'b1;
      repeat (10) queue_random_req();
      // drop the long fades before the short settings
      if (p == 0) queue_req(OP_RESTART, 0, 0, 0, 0);
      drain();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/mfng_pkg.sv
hdl/mfng_if.sv
hdl/mfng_ram.sv
hdl/mfng_mac.sv
hdl/multiband_fir_noise_gate.sv
verif/multiband_fir_noise_gate_tb.sv
